/* sv/touch_packet_decode_calibrate_unit_assert.svh */
// ----------------------------------------------------------------------------
// touch report decoder assertion macros
// shared macros for the concurrent checks of the touch report decoder
// ----------------------------------------------------------------------------
`ifndef TOUCH_PACKET_DECODE_CALIBRATE_UNIT_ASSERT_SVH
`define TOUCH_PACKET_DECODE_CALIBRATE_UNIT_ASSERT_SVH

// same-cycle implication
`define TPDC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TPDC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* sv/tpdc_pkg.sv */
// ----------------------------------------------------------------------------
// touch report decoder package
// widths, register indexes, sequencer states and shared structs
// ----------------------------------------------------------------------------
package tpdc_pkg;

    localparam int CoordBits   = 12;
    localparam int ReportBytes = 5;
    localparam int ByteBits    = 8;
    localparam int LenBits     = 4;
    localparam int CfgIdxBits  = 3;
    localparam int CfgDataBits = 12;
    localparam int DivCntBits  = $clog2(CoordBits + 1);

    typedef logic [CoordBits-1:0]   coord_t;
    typedef logic [2*CoordBits-1:0] dividend_t;
    typedef logic [ByteBits-1:0]    byte_t;

    localparam coord_t CoordMax = '1;
    localparam byte_t  SyncMask = 8'h80;
    localparam byte_t  HighMask = 8'h1f;
    localparam byte_t  LowMask  = 8'h7f;

    typedef enum logic [CfgIdxBits-1:0] {
        CFG_MIN_X,
        CFG_MAX_X,
        CFG_MIN_Y,
        CFG_MAX_Y,
        CFG_SWAP_XY,
        CFG_FLIP_X,
        CFG_FLIP_Y
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_X_PREP,
        ST_X_DIV,
        ST_Y_PREP,
        ST_Y_DIV,
        ST_DONE
    } seq_state_t;

    typedef struct packed {
        logic   ok;
        logic   down;
        coord_t raw_x;
        coord_t raw_y;
        coord_t x;
        coord_t y;
    } dec_t;

    typedef struct packed {
        logic      start;
        dividend_t dividend;
        coord_t    divisor;
    } div_req_t;

    typedef struct packed {
        logic   busy;
        logic   done;
        coord_t quotient;
    } div_rsp_t;

endpackage

/* sv/tpdc_decode.sv */
// ----------------------------------------------------------------------------
// touch report decode
// checks a report, assembles raw x and y, applies axis swap and inversion
// ----------------------------------------------------------------------------
module tpdc_decode import tpdc_pkg::*; (
    input  byte_t              sync_byte,
    input  byte_t              x_low_byte,
    input  byte_t              x_high_byte,
    input  byte_t              y_low_byte,
    input  byte_t              y_high_byte,
    input  logic [LenBits-1:0] packet_length,
    input  logic               swap_xy,
    input  logic               flip_x,
    input  logic               flip_y,
    output dec_t               dec
);

    byte_t  data_or;
    coord_t raw_x;
    coord_t raw_y;
    coord_t sw_x;
    coord_t sw_y;
    byte_t  xh;
    byte_t  xl;
    byte_t  yh;
    byte_t  yl;

    always_comb begin
        data_or = x_low_byte | x_high_byte | y_low_byte | y_high_byte;
        xh      = x_high_byte & HighMask;
        xl      = x_low_byte & LowMask;
        yh      = y_high_byte & HighMask;
        yl      = y_low_byte & LowMask;
        raw_x   = {xh[4:0], xl[6:0]};
        raw_y   = {yh[4:0], yl[6:0]};
        sw_x    = swap_xy ? raw_y : raw_x;
        sw_y    = swap_xy ? raw_x : raw_y;

        dec.ok    = (packet_length >= LenBits'(ReportBytes))
                    && ((sync_byte & SyncMask) != '0)
                    && ((data_or & SyncMask) == '0);
        dec.down  = sync_byte[0];
        dec.raw_x = raw_x;
        dec.raw_y = raw_y;
        dec.x     = flip_x ? CoordMax - sw_x : sw_x;
        dec.y     = flip_y ? CoordMax - sw_y : sw_y;
    end

endmodule

/* sv/tpdc_divider.sv */
// ----------------------------------------------------------------------------
// touch report serial divider
// restoring divider, one quotient bit per cycle, quotient known to fit
// ----------------------------------------------------------------------------
module tpdc_divider import tpdc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DivCntBits-1:0] count_reg, count_next;
    logic                  done_reg, done_next;
    coord_t                rem_reg, rem_next;
    coord_t                sh_reg, sh_next;
    coord_t                den_reg, den_next;
    logic [CoordBits:0]    trial;
    logic [CoordBits:0]    trial_diff;
    logic                  ge;

    always_comb begin
        trial      = {rem_reg, sh_reg[CoordBits-1]};
        trial_diff = trial - {1'b0, den_reg};
        ge         = trial >= {1'b0, den_reg};
        count_next = count_reg;
        done_next  = 1'b0;
        rem_next   = rem_reg;
        sh_next    = sh_reg;
        den_next   = den_reg;
        if (req.start) begin
            // upper half is below the divisor, so it seeds the remainder
            rem_next   = req.dividend[2*CoordBits-1:CoordBits];
            sh_next    = req.dividend[CoordBits-1:0];
            den_next   = req.divisor;
            count_next = DivCntBits'(CoordBits);
        end else if (count_reg != '0) begin
            rem_next   = ge ? trial_diff[CoordBits-1:0] : trial[CoordBits-1:0];
            sh_next    = {sh_reg[CoordBits-2:0], ge};
            count_next = count_reg - 1'b1;
            done_next  = (count_reg == DivCntBits'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        den_reg <= den_next;
    end

    assign rsp.busy     = (count_reg != '0);
    assign rsp.done     = done_reg;
    assign rsp.quotient = sh_reg;

endmodule

/* sv/touch_packet_decode_calibrate_unit.sv */
// ----------------------------------------------------------------------------
// touch report decoder with linear calibration
// Takes one five-byte touch report per transfer. Short reports, reports
// without the sync bit and reports with bit 7 set in a data byte are dropped
// with no result. Good reports give calibrated x and y, the touch status and
// the last pen-up raw point. One report is processed at a time: s_ready is
// high only while the sequencer is idle, and a dropped report leaves the
// block ready. Both axes share the single 12-step serial divider in turn;
// an axis that clamps skips it. A finished result waits in the output
// register, and the next report may be taken meanwhile.
// ----------------------------------------------------------------------------
`include "touch_packet_decode_calibrate_unit_assert.svh"

module touch_packet_decode_calibrate_unit import tpdc_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CfgIdxBits-1:0]  cfg_index,
    input  logic [CfgDataBits-1:0] cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  byte_t                  s_sync_byte,
    input  byte_t                  s_x_low_byte,
    input  byte_t                  s_x_high_byte,
    input  byte_t                  s_y_low_byte,
    input  byte_t                  s_y_high_byte,
    input  logic [LenBits-1:0]     s_packet_length,
    output logic                   m_valid,
    input  logic                   m_ready,
    output coord_t                 m_x_position,
    output coord_t                 m_y_position,
    output logic                   m_touch_down,
    output coord_t                 m_last_up_x,
    output coord_t                 m_last_up_y
);

    coord_t     cal_min_x_reg, cal_max_x_reg, cal_min_y_reg, cal_max_y_reg;
    logic       swap_xy_reg, flip_x_reg, flip_y_reg;
    coord_t     pen_up_x_reg, pen_up_y_reg;
    seq_state_t state_reg, state_next;
    coord_t     x_reg, y_reg;
    logic       down_reg;
    coord_t     xpos_reg, xpos_next;
    coord_t     ypos_reg, ypos_next;
    logic       m_valid_reg;
    coord_t     m_x_reg, m_y_reg, m_up_x_reg, m_up_y_reg;
    logic       m_down_reg;
    logic       in_xfer;
    logic       load_out;
    dec_t       dec;
    div_req_t   div_req;
    div_rsp_t   div_rsp;
    logic       div_start;
    logic       axis_y;
    coord_t     v, lo, hi, diff;
    logic       below, above, empty;
    coord_t     direct;
    logic       need_div;

    tpdc_decode u_decode (
        .sync_byte     (s_sync_byte),
        .x_low_byte    (s_x_low_byte),
        .x_high_byte   (s_x_high_byte),
        .y_low_byte    (s_y_low_byte),
        .y_high_byte   (s_y_high_byte),
        .packet_length (s_packet_length),
        .swap_xy       (swap_xy_reg),
        .flip_x        (flip_x_reg),
        .flip_y        (flip_y_reg),
        .dec           (dec)
    );

    tpdc_divider u_divider (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign in_xfer = s_valid && s_ready;

    // calibration window of the axis in hand
    always_comb begin
        axis_y   = (state_reg == ST_Y_PREP);
        v        = axis_y ? y_reg : x_reg;
        lo       = axis_y ? cal_min_y_reg : cal_min_x_reg;
        hi       = axis_y ? cal_max_y_reg : cal_max_x_reg;
        below    = v < lo;
        above    = v > hi;
        empty    = hi == lo;
        diff     = v - lo;
        direct   = (!below && above) ? CoordMax : '0;
        need_div = !below && !above && !empty;
        div_req.start    = div_start;
        div_req.dividend = {diff, {CoordBits{1'b0}}} - {{CoordBits{1'b0}}, diff};
        div_req.divisor  = hi - lo;
    end

    always_comb begin
        state_next = state_reg;
        xpos_next  = xpos_reg;
        ypos_next  = ypos_reg;
        div_start  = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer && dec.ok) begin
                    state_next = ST_X_PREP;
                end
            end
            ST_X_PREP: begin
                xpos_next  = direct;
                div_start  = need_div;
                state_next = need_div ? ST_X_DIV : ST_Y_PREP;
            end
            ST_X_DIV: begin
                if (div_rsp.done) begin
                    xpos_next  = div_rsp.quotient;
                    state_next = ST_Y_PREP;
                end
            end
            ST_Y_PREP: begin
                ypos_next  = direct;
                div_start  = need_div;
                state_next = need_div ? ST_Y_DIV : ST_DONE;
            end
            ST_Y_DIV: begin
                if (div_rsp.done) begin
                    ypos_next  = div_rsp.quotient;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_min_x_reg <= '0;
            cal_max_x_reg <= CoordMax;
            cal_min_y_reg <= '0;
            cal_max_y_reg <= CoordMax;
            swap_xy_reg   <= 1'b0;
            flip_x_reg    <= 1'b0;
            flip_y_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_MIN_X:   cal_min_x_reg <= cfg_wdata[CoordBits-1:0];
                CFG_MAX_X:   cal_max_x_reg <= cfg_wdata[CoordBits-1:0];
                CFG_MIN_Y:   cal_min_y_reg <= cfg_wdata[CoordBits-1:0];
                CFG_MAX_Y:   cal_max_y_reg <= cfg_wdata[CoordBits-1:0];
                CFG_SWAP_XY: swap_xy_reg   <= cfg_wdata[0];
                CFG_FLIP_X:  flip_x_reg    <= cfg_wdata[0];
                CFG_FLIP_Y:  flip_y_reg    <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // last pen-up point
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pen_up_x_reg <= '0;
            pen_up_y_reg <= '0;
        end else if (in_xfer && dec.ok && !dec.down) begin
            pen_up_x_reg <= dec.raw_x;
            pen_up_y_reg <= dec.raw_y;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            x_reg    <= dec.x;
            y_reg    <= dec.y;
            down_reg <= dec.down;
        end
        xpos_reg <= xpos_next;
        ypos_reg <= ypos_next;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (load_out) begin
            m_x_reg    <= xpos_reg;
            m_y_reg    <= ypos_reg;
            m_down_reg <= down_reg;
            m_up_x_reg <= pen_up_x_reg;
            m_up_y_reg <= pen_up_y_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_x_position = m_x_reg;
    assign m_y_position = m_y_reg;
    assign m_touch_down = m_down_reg;
    assign m_last_up_x  = m_up_x_reg;
    assign m_last_up_y  = m_up_y_reg;

    `TPDC_ASSERT_NOW(a_div_start_idle, div_req.start, !div_rsp.busy,
        "divider started while busy")
    `TPDC_ASSERT_NOW(a_div_done_state, div_rsp.done,
        state_reg == ST_X_DIV || state_reg == ST_Y_DIV,
        "divider result outside a division state")
    `TPDC_ASSERT_NEXT(a_out_load, load_out, m_valid && state_reg == ST_IDLE,
        "result not presented after load")
    `TPDC_ASSERT_NOW(a_busy_not_ready, div_rsp.busy, !s_ready,
        "report taken during division")

endmodule
